/* hw/rtl/mhnt_pkg.sv */
// mhnt_pkg: shared constants, types and controller/datapath interface structs
// for the held-note tracker. no dependencies.

package mhnt_pkg;

  localparam int CHANNELS = 16;
  localparam int KEYS     = 128;
  localparam int SLOTS    = CHANNELS * KEYS;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = 8;
  localparam int TOT_W    = 19;

  localparam logic [7:0] COUNT_MAX = 8'd255;
  localparam logic [7:0] KIND_ON   = 8'h90;
  localparam logic [7:0] KIND_OFF  = 8'h80;
  localparam logic [7:0] KIND_MASK = 8'hf0;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TOT_W-1:0]  total_t;
  typedef logic [TOT_W:0]    cum_t;
  typedef logic [3:0]        chan_t;
  typedef logic [6:0]        key_t;

  // controller to datapath
  typedef struct packed {
    logic ld_in;
    logic clr_wr;
    logic rec_rd;
    logic rec_wr;
    logic scan_start;
    logic scan_step;
    logic res_miss;
    logic res_hit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_sel;
    logic rank_miss;
    logic hit;
  } sts_t;

endpackage

/* hw/rtl/midi_held_note_tracker.sv */
// midi_held_note_tracker: top level of the held-note tracker, joining the
// sequencer (mhnt_ctrl) and the datapath (mhnt_dp). depends on mhnt_pkg.
//
//   port group   direction   handshake              contents
//   in_*         in          in_valid / in_ready    one request word
//   out_*        out         out_valid / out_ready  one result word per request
//
// record: accept, count read, write-back with result load
// select: a miss result when the rank is at or above the total, otherwise
//   a scan from slot 0 up to the slot of the hit, one counter per cycle
//   through the single read port of the count ram
// reset: synchronous, active low; followed by a clearing pass over all
//   2048 slots of the count ram, during which in_ready stays low
// stalls: a finished result waits in its last step until the result
//   register is free; one request is in flight at a time

module midi_held_note_tracker (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_status_byte,
  input  logic [7:0]  in_key_byte,
  input  logic [7:0]  in_velocity_byte,
  input  logic        in_delivered,
  input  logic [18:0] in_rank,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_found,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_note,
  output logic [18:0] out_held_total
);

  // command and status between sequencer and datapath
  mhnt_pkg::cmd_t cmd;
  mhnt_pkg::sts_t sts;

  // sequencer: clearing pass, request decode, scan control, result valid
  mhnt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: count ram, running total, cumulative rank scan, result word
  mhnt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_status_byte   (in_status_byte),
    .in_key_byte      (in_key_byte),
    .in_velocity_byte (in_velocity_byte),
    .in_delivered     (in_delivered),
    .in_rank          (in_rank),
    .out_accepted     (out_accepted),
    .out_found        (out_found),
    .out_channel      (out_channel),
    .out_note         (out_note),
    .out_held_total   (out_held_total)
  );

endmodule

/* hw/rtl/mhnt_ram.sv */
// mhnt_ram: generic single-write, single-read ram with registered read data.
// no dependencies.

module mhnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/mhnt_ctrl.sv */
// mhnt_ctrl: sequencer for clearing pass, record and select requests, and
// the result word's valid flag. depends on mhnt_pkg.

module mhnt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mhnt_pkg::sts_t     sts,
  output mhnt_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_REC_WB,
    S_SEL_MISS,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   load;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    load      = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_sel) begin
          if (sts.rank_miss) begin
            state_nxt = S_SEL_MISS;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else begin
          cmd.rec_rd = 1'b1;
          state_nxt  = S_REC_WB;
        end
      end
      S_REC_WB: begin
        if (out_free) begin
          cmd.rec_wr = 1'b1;
          load       = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SEL_MISS: begin
        if (out_free) begin
          cmd.res_miss = 1'b1;
          load         = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          if (out_free) begin
            cmd.res_hit = 1'b1;
            load        = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/mhnt_dp.sv */
// mhnt_dp: request registers, count store, running total, rank scan and
// result registers. depends on mhnt_pkg and mhnt_ram.

module mhnt_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mhnt_pkg::cmd_t       cmd,
  output mhnt_pkg::sts_t       sts,
  input  logic                 in_req_type,
  input  logic [7:0]           in_status_byte,
  input  logic [7:0]           in_key_byte,
  input  logic [7:0]           in_velocity_byte,
  input  logic                 in_delivered,
  input  logic [18:0]          in_rank,
  output logic                 out_accepted,
  output logic                 out_found,
  output logic [3:0]           out_channel,
  output logic [6:0]           out_note,
  output logic [18:0]          out_held_total
);

  // latched request
  logic                 is_sel_r;
  logic [7:0]           status_r;
  mhnt_pkg::key_t       key_r;
  logic [6:0]           vel_r;
  logic                 deliv_r;
  mhnt_pkg::total_t     rank_r;

  mhnt_pkg::total_t     sum_r, sum_nxt;
  mhnt_pkg::slot_t      addr_r;
  mhnt_pkg::total_t     cum_r;
  mhnt_pkg::chan_t      dch_r;
  mhnt_pkg::key_t       dkey_r;

  logic                 acc_r, found_r;
  mhnt_pkg::chan_t      ch_r;
  mhnt_pkg::key_t       note_r;
  mhnt_pkg::total_t     tot_r;

  // ram ports
  logic                 wr_en, rd_en;
  mhnt_pkg::slot_t      wr_addr, rd_addr;
  mhnt_pkg::cnt_t       wr_data, cnt;

  // record decode
  mhnt_pkg::chan_t      chan;
  logic [7:0]           kind;
  logic                 in_range, is_note, on, off, refuse, acc, inc, dec;
  mhnt_pkg::slot_t      slot;
  mhnt_pkg::cnt_t       new_cnt;
  mhnt_pkg::cum_t       cum_next;

  assign chan     = status_r[3:0];
  assign kind     = status_r & mhnt_pkg::KIND_MASK;
  assign in_range = ({1'b0, chan} < 5'(mhnt_pkg::CHANNELS)) &&
                    ({1'b0, key_r} < 8'(mhnt_pkg::KEYS));
  assign is_note  = ((kind == mhnt_pkg::KIND_ON) || (kind == mhnt_pkg::KIND_OFF)) && in_range;
  assign on       = is_note && (kind == mhnt_pkg::KIND_ON) && (vel_r != 7'd0);
  assign off      = is_note && !on;
  assign slot     = mhnt_pkg::slot_t'(int'(chan) * mhnt_pkg::KEYS + int'(key_r));

  assign refuse   = on && (cnt == mhnt_pkg::COUNT_MAX);
  assign acc      = !refuse && deliv_r;
  assign inc      = acc && on;
  assign dec      = acc && off && (cnt != '0);
  assign new_cnt  = inc ? cnt + 1'b1 : cnt - 1'b1;

  always_comb begin
    if (inc) begin
      sum_nxt = sum_r + 1'b1;
    end else if (dec) begin
      sum_nxt = sum_r - 1'b1;
    end else begin
      sum_nxt = sum_r;
    end
  end

  // scan: data arriving belongs to slot (dch_r, dkey_r)
  assign cum_next = mhnt_pkg::cum_t'(cum_r) + mhnt_pkg::cum_t'(cnt);

  assign sts.clr_last  = (addr_r == mhnt_pkg::slot_t'(mhnt_pkg::SLOTS - 1));
  assign sts.is_sel    = is_sel_r;
  assign sts.rank_miss = (rank_r >= sum_r);
  assign sts.hit       = ({1'b0, rank_r} < cum_next);

  assign wr_en   = cmd.clr_wr || (cmd.rec_wr && (inc || dec));
  assign wr_addr = cmd.clr_wr ? addr_r : slot;
  assign wr_data = cmd.clr_wr ? '0 : new_cnt;
  assign rd_en   = cmd.rec_rd || cmd.scan_start || cmd.scan_step;

  always_comb begin
    if (cmd.rec_rd) begin
      rd_addr = slot;
    end else if (cmd.scan_start) begin
      rd_addr = '0;
    end else begin
      rd_addr = addr_r;
    end
  end

  mhnt_ram #(
    .WIDTH (mhnt_pkg::CNT_W),
    .DEPTH (mhnt_pkg::SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (cnt)
  );

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      addr_r <= '0;
    end else begin
      if (cmd.rec_wr) begin
        sum_r <= sum_nxt;
      end
      if (cmd.clr_wr) begin
        addr_r <= sts.clr_last ? '0 : addr_r + 1'b1;
      end else if (cmd.scan_start) begin
        addr_r <= mhnt_pkg::slot_t'(1);
      end else if (cmd.scan_step) begin
        addr_r <= addr_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      is_sel_r <= (in_req_type == mhnt_pkg::REQ_SELECT);
      status_r <= in_status_byte;
      key_r    <= in_key_byte[6:0];
      vel_r    <= in_velocity_byte[6:0];
      deliv_r  <= in_delivered;
      rank_r   <= in_rank;
    end
    if (cmd.scan_start) begin
      cum_r  <= '0;
      dch_r  <= '0;
      dkey_r <= '0;
    end else if (cmd.scan_step) begin
      cum_r <= mhnt_pkg::total_t'(cum_next);
      if (dkey_r == mhnt_pkg::key_t'(mhnt_pkg::KEYS - 1)) begin
        dkey_r <= '0;
        dch_r  <= dch_r + 1'b1;
      end else begin
        dkey_r <= dkey_r + 1'b1;
      end
    end
    if (cmd.rec_wr) begin
      acc_r   <= acc;
      found_r <= 1'b0;
      ch_r    <= '0;
      note_r  <= '0;
      tot_r   <= sum_nxt;
    end else if (cmd.res_miss) begin
      acc_r   <= 1'b0;
      found_r <= 1'b0;
      ch_r    <= '0;
      note_r  <= '0;
      tot_r   <= sum_r;
    end else if (cmd.res_hit) begin
      acc_r   <= 1'b0;
      found_r <= 1'b1;
      ch_r    <= dch_r;
      note_r  <= dkey_r;
      tot_r   <= sum_r;
    end
  end

  assign out_accepted   = acc_r;
  assign out_found      = found_r;
  assign out_channel    = ch_r;
  assign out_note       = note_r;
  assign out_held_total = tot_r;

endmodule

/* hw/rtl/mhnt_chk.sv */
// mhnt_chk: port-level checks for midi_held_note_tracker, bound to the top
// level. no package dependency.

module mhnt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic        out_found,
  input logic [3:0]  out_channel,
  input logic [6:0]  out_note,
  input logic [18:0] out_held_total
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) &&
    $stable(out_found) && $stable(out_channel) && $stable(out_note) &&
    $stable(out_held_total))
    else $error("stalled result word changed");

  // one request in flight: no second accept right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // record and select results never mix
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_found))
    else $error("accepted and found both set");

  // a result without a hit carries zero location
  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_channel == 4'd0 && out_note == 7'd0)
    else $error("location set without a hit");

endmodule

bind midi_held_note_tracker mhnt_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_accepted   (out_accepted),
  .out_found      (out_found),
  .out_channel    (out_channel),
  .out_note       (out_note),
  .out_held_total (out_held_total)
);
